>>> hdl/periodic_task_timer_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task timer table unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared constants for the periodic task timer table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int TICK_W       = 32;
	localparam int MEM_W        = 2 * TICK_W;   // {period, deadline}

	localparam logic [2:0] OP_SET     = 3'd0;
	localparam logic [2:0] OP_CLEAR   = 3'd1;
	localparam logic [2:0] OP_SUSPEND = 3'd2;
	localparam logic [2:0] OP_RESUME  = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;

	typedef logic [CH_W-1:0] ch_idx_t;
	typedef logic [TICK_W-1:0] tick_t;

endpackage

`default_nettype wire

>>> hdl/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                                          clk,
	input  wire logic                                          wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  wire logic [WIDTH-1:0]                              wr_data,
	input  wire logic                                          rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output logic      [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/periodic_task_timer_table_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_table_unit
// Table of periodic timer channels: set, clear, suspend, resume and tick.
// Period and deadline live in one RAM; flag bits live in flops.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | opcode, channel, period, now_tick, keep_mask
//  out     | out_valid/out_ready | fired_channel, fired, last
//
//  Set, clear, suspend and resume are taken while idle (in_ready stays high).
//  A tick scans every channel: one RAM read per channel, the
//  evaluate/write-back of each channel overlapping the next read, then a
//  flush of the held result. Output stalls stretch the scan by the stall.
//  RAM is not cleared at reset: a per-entry written bit makes untouched
//  entries read as zero, so the block is ready right out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_timer_table_unit_assert.svh"

module periodic_task_timer_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [3:0]  channel,
	input  wire logic [31:0] period,
	input  wire logic [31:0] now_tick,
	input  wire logic [7:0]  keep_mask,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       fired_channel,
	output logic             fired,
	output logic             last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	localparam int N = ptt_pkg::NUM_CHANNELS;

	logic [1:0]         state_q;
	ptt_pkg::ch_idx_t   idx_q;
	ptt_pkg::tick_t     now_q;
	logic [7:0]         keep_q;
	logic [N-1:0]       en_q;
	logic [N-1:0]       wrap_q;
	logic [N-1:0]       mark_q;
	logic [N-1:0]       written_q;
	logic               pend_valid_q;
	ptt_pkg::ch_idx_t   pend_ch_q;
	logic               out_valid_q;
	logic [2:0]         fired_channel_q;
	logic               fired_q;
	logic               last_q;

	logic                      in_acc;
	logic                      ch_one;
	logic                      ch_all;
	ptt_pkg::ch_idx_t          ch_idx;
	logic                      out_free;
	logic [ptt_pkg::MEM_W-1:0] rd_data;
	ptt_pkg::tick_t            rd_dl;
	ptt_pkg::tick_t            rd_per;
	ptt_pkg::tick_t            new_dl;
	logic                      fire;
	logic                      scan_go;
	logic                      last_idx;
	logic                      keep_bit;
	logic                      out_load;
	logic                      ram_we;
	ptt_pkg::ch_idx_t          ram_waddr;
	logic [ptt_pkg::MEM_W-1:0] ram_wdata;
	logic                      ram_re;
	ptt_pkg::ch_idx_t          ram_raddr;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign ch_one   = int'(channel) < N;
	assign ch_all   = int'(channel) == N;
	assign ch_idx   = ptt_pkg::CH_W'(channel);
	assign out_free = !out_valid_q || out_ready;

	// untouched entries read as zero
	assign rd_dl    = written_q[idx_q] ? rd_data[ptt_pkg::TICK_W-1:0] : '0;
	assign rd_per   = written_q[idx_q] ? rd_data[ptt_pkg::MEM_W-1:ptt_pkg::TICK_W] : '0;
	assign new_dl   = now_q + rd_per;
	assign fire     = (state_q == ST_SCAN) && en_q[idx_q] && (now_q >= rd_dl);
	// a second fire needs the output register to take the held word
	assign scan_go  = (state_q == ST_SCAN) && !(fire && pend_valid_q && !out_free);
	assign last_idx = (idx_q == ptt_pkg::CH_W'(N - 1));
	assign keep_bit = (int'(idx_q) < 8) ? keep_q[3'(idx_q)] : 1'b0;
	assign out_load = (scan_go && fire && pend_valid_q) || ((state_q == ST_FLUSH) && out_free);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {rd_per, new_dl};
		if (in_acc && (opcode == ptt_pkg::OP_SET) && ch_one) begin
			ram_we    = 1'b1;
			ram_waddr = ch_idx;
			ram_wdata = {period, now_tick + period};
		end else if (scan_go && fire) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = (in_acc && (opcode == ptt_pkg::OP_TICK)) || (scan_go && !last_idx);
	assign ram_raddr = in_acc ? '0 : ptt_pkg::CH_W'(idx_q + 1'b1);

	ptt_ram #(
		.WIDTH (ptt_pkg::MEM_W),
		.DEPTH (N)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_data)
	);

	// tick operands
	always_ff @(posedge clk) begin
		if (in_acc && (opcode == ptt_pkg::OP_TICK)) begin
			now_q  <= now_tick;
			keep_q <= keep_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			en_q         <= '0;
			wrap_q       <= '0;
			mark_q       <= '0;
			written_q    <= '0;
			pend_valid_q <= 1'b0;
			pend_ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (opcode)
							ptt_pkg::OP_SET: begin
								if (ch_one) begin
									en_q[ch_idx]      <= 1'b1;
									written_q[ch_idx] <= 1'b1;
								end
							end
							ptt_pkg::OP_CLEAR: begin
								if (ch_one) begin
									en_q[ch_idx] <= 1'b0;
								end
							end
							ptt_pkg::OP_SUSPEND: begin
								if (ch_one) begin
									en_q[ch_idx] <= 1'b0;
								end else if (ch_all) begin
									mark_q <= mark_q | en_q;
									en_q   <= '0;
								end
							end
							ptt_pkg::OP_RESUME: begin
								if (ch_one) begin
									en_q[ch_idx] <= 1'b1;
								end else if (ch_all) begin
									en_q   <= en_q | mark_q;
									mark_q <= '0;
								end
							end
							ptt_pkg::OP_TICK: begin
								state_q <= ST_SCAN;
								idx_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (fire) begin
							en_q[idx_q]      <= keep_bit;
							written_q[idx_q] <= 1'b1;
							wrap_q[idx_q]    <= wrap_q[idx_q] ? 1'b0 : (new_dl < now_q);
							pend_valid_q     <= 1'b1;
							pend_ch_q        <= idx_q;
						end
						if (last_idx) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= ptt_pkg::CH_W'(idx_q + 1'b1);
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// held word goes out as non-last on the next fire, as last at flush
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_FLUSH) begin
				fired_channel_q <= pend_valid_q ? 3'(pend_ch_q) : 3'd0;
				fired_q         <= pend_valid_q;
				last_q          <= 1'b1;
			end else begin
				fired_channel_q <= 3'(pend_ch_q);
				fired_q         <= 1'b1;
				last_q          <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign fired_channel = fired_channel_q;
	assign fired         = fired_q;
	assign last          = last_q;

	`PTT_ASSERT_IMP(a_idle_no_pend, in_ready, !pend_valid_q, "pending word while idle")
	`PTT_ASSERT_IMP(a_empty_is_last, out_valid && !fired, last, "empty tick word not last")
	`PTT_ASSERT_IMP(a_fire_writes, scan_go && fire, ram_we && (ram_waddr == idx_q), "fire without write-back")
	`PTT_ASSERT_NXT(a_flush_done, (state_q == ST_FLUSH) && out_free, in_ready && out_valid && last, "flush did not finish")

endmodule

`default_nettype wire
